FILE: design/afk_pkg.sv
// Shared types, constants and arithmetic helpers for the four-joint arm kinematics block.
package afk_pkg;

   localparam int ANGLE_W = 16;
   localparam int QTR_W   = ANGLE_W - 1;
   localparam int Z_W     = 31;
   localparam int Z_SHIFT = 32 - ANGLE_W;
   localparam int TRIG_W  = 16;
   localparam int LEN_W   = 16;
   localparam int POS_W   = 20;
   localparam int LANES   = 8;
   localparam int NANG    = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [QTR_W-1:0] QUARTER = QTR_W'(1) << (ANGLE_W - 2);

   localparam logic [Z_W-1:0] SIN_COEF [5] = '{
      31'd1686629713, 31'd693598668, 31'd85569305, 31'd5026995, 31'd172272
   };

   localparam logic [1:0] REG_BASE_OFFSET = 2'd0;
   localparam logic [1:0] REG_UPPER_LINK  = 2'd1;
   localparam logic [1:0] REG_FORE_LINK   = 2'd2;
   localparam logic [1:0] REG_WRIST_LINK  = 2'd3;

   localparam logic [LEN_W-1:0] UPPER_RESET = 16'd1597;
   localparam logic [LEN_W-1:0] FORE_RESET  = 16'd1475;
   localparam logic [LEN_W-1:0] WRIST_RESET = 16'd573;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [1:0]       quad;
      logic [QTR_W-1:0] rs;
      logic [QTR_W-1:0] rc;
   } angle_split_type;

   typedef struct packed {
      angle_split_type [NANG-1:0] ang;
   } word_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] s1;
      logic signed [TRIG_W-1:0] c1;
      logic signed [TRIG_W-1:0] s2;
      logic signed [TRIG_W-1:0] c2;
      logic signed [TRIG_W-1:0] s23;
      logic signed [TRIG_W-1:0] c23;
      logic signed [TRIG_W-1:0] s234;
      logic signed [TRIG_W-1:0] c234;
   } trig_type;

   typedef struct packed {
      logic [LEN_W-1:0] a0;
      logic [LEN_W-1:0] a1;
      logic [LEN_W-1:0] a2;
      logic [LEN_W-1:0] a3;
   } link_type;

   function automatic angle_split_type split_angle(input logic [ANGLE_W-1:0] a);
      angle_split_type s;
      s.quad = a[ANGLE_W-1 -: 2];
      s.rs   = QTR_W'(a[ANGLE_W-3:0]);
      s.rc   = QUARTER - s.rs;
      return s;
   endfunction

   function automatic logic [Z_W-1:0] residue_to_z(input logic [QTR_W-1:0] r);
      logic [Z_W-1:0] z;
      z = Z_W'(r) << Z_SHIFT;
      return z;
   endfunction

   // (a * b) >> 30, result known to fit 31 bits
   function automatic logic [Z_W-1:0] mul_q30(input logic [Z_W-1:0] a,
                                             input logic [Z_W-1:0] b);
      logic [2*Z_W-1:0] p;
      p = a * b;
      return p[Z_W+29:30];
   endfunction

   // round half up to Q15, saturate at 32767 (just under +1)
   function automatic logic [TRIG_W-1:0] q30_to_q15(input logic [Z_W-1:0] z,
                                                   input logic [Z_W-1:0] t);
      logic [2*Z_W-1:0] p;
      logic [32:0]      s;
      logic [17:0]      q;
      p = z * t;
      s = 33'(p[2*Z_W-1:30]) + 33'd16384;
      q = s[32:15];
      if (q > 18'd32767) begin
         q = 18'd32767;
      end
      return q[TRIG_W-1:0];
   endfunction

   function automatic logic signed [TRIG_W:0] round_q15(input logic signed [31:0] p);
      logic signed [32:0] v;
      v = 33'(p) + 33'sd16384;
      return 17'(v >>> 15);
   endfunction

endpackage

FILE: design/afk_front.sv
// Front end: takes joint words, forms angle sums and splits each angle into quadrant and residues.
module afk_front (
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [afk_pkg::ANGLE_W-1:0]    req_joint_one,
   input  logic [afk_pkg::ANGLE_W-1:0]    req_joint_two,
   input  logic [afk_pkg::ANGLE_W-1:0]    req_joint_three,
   input  logic [afk_pkg::ANGLE_W-1:0]    req_joint_four,
   input  logic                           queue_full,
   output logic                           push,
   output afk_pkg::word_type              push_word
);
   import afk_pkg::*;

   logic [ANGLE_W-1:0] t23;
   logic [ANGLE_W-1:0] t234;

   always_comb begin
      t23  = req_joint_two + req_joint_three;
      t234 = t23 + req_joint_four;
      push_word.ang[0] = split_angle(req_joint_one);
      push_word.ang[1] = split_angle(req_joint_two);
      push_word.ang[2] = split_angle(t23);
      push_word.ang[3] = split_angle(t234);
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

FILE: design/afk_queue.sv
// Short queue of classified words between front and back.
module afk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  afk_pkg::word_type push_word,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output afk_pkg::word_type head_word
);
   import afk_pkg::*;

   word_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_word  = mem_ff[rd_ff];

endmodule

FILE: design/afk_sincos.sv
// Eight-lane pipelined polynomial sine unit with quadrant folding.
module afk_sincos (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              head_valid,
   input  afk_pkg::word_type head_word,
   output logic              pop,
   output logic              trig_valid,
   output afk_pkg::trig_type trig
);
   import afk_pkg::*;

   // stage 0 loads z, stages 1..4 run Horner steps
   logic [Z_W-1:0]    z_ff  [5][LANES];
   logic [Z_W-1:0]    z2_ff [5][LANES];
   logic [Z_W-1:0]    t_ff  [5][LANES];
   logic [1:0]        quad_ff [6][NANG];
   logic [TRIG_W-1:0] sq_ff [LANES];
   logic signed [TRIG_W-1:0] sin_ff [NANG];
   logic signed [TRIG_W-1:0] cos_ff [NANG];
   logic [6:0]        v_ff, v_in;

   logic [Z_W-1:0]    z0_in [LANES];
   logic [Z_W-1:0]    t_in  [5][LANES];
   logic [TRIG_W-1:0] sq_in [LANES];
   logic signed [TRIG_W-1:0] sin_in [NANG];
   logic signed [TRIG_W-1:0] cos_in [NANG];
   logic signed [TRIG_W-1:0] sr;
   logic signed [TRIG_W-1:0] cr;

   assign pop = adv && head_valid;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         z0_in[j] = (j % 2 == 0) ? residue_to_z(head_word.ang[j/2].rs)
                                 : residue_to_z(head_word.ang[j/2].rc);
         t_in[0][j] = '0;
         t_in[1][j] = SIN_COEF[3] - mul_q30(z2_ff[0][j], SIN_COEF[4]);
         for (int i = 2; i < 5; i++) begin
            t_in[i][j] = SIN_COEF[4-i] - mul_q30(z2_ff[i-1][j], t_ff[i-1][j]);
         end
         sq_in[j] = q30_to_q15(z_ff[4][j], t_ff[4][j]);
      end
      for (int k = 0; k < NANG; k++) begin
         sr = $signed(sq_ff[2*k]);
         cr = $signed(sq_ff[2*k+1]);
         case (quad_ff[5][k])
            QUAD_0: begin
               sin_in[k] = sr;
               cos_in[k] = cr;
            end
            QUAD_1: begin
               sin_in[k] = cr;
               cos_in[k] = -sr;
            end
            QUAD_2: begin
               sin_in[k] = -sr;
               cos_in[k] = -cr;
            end
            default: begin
               sin_in[k] = -cr;
               cos_in[k] = sr;
            end
         endcase
      end
      v_in = {v_ff[5:0], pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < LANES; j++) begin
            z_ff[0][j]  <= z0_in[j];
            z2_ff[0][j] <= mul_q30(z0_in[j], z0_in[j]);
            t_ff[0][j]  <= '0;
            for (int i = 1; i < 5; i++) begin
               z_ff[i][j]  <= z_ff[i-1][j];
               z2_ff[i][j] <= z2_ff[i-1][j];
               t_ff[i][j]  <= t_in[i][j];
            end
            sq_ff[j] <= sq_in[j];
         end
         for (int k = 0; k < NANG; k++) begin
            quad_ff[0][k] <= head_word.ang[k].quad;
            for (int i = 1; i < 6; i++) begin
               quad_ff[i][k] <= quad_ff[i-1][k];
            end
            sin_ff[k] <= sin_in[k];
            cos_ff[k] <= cos_in[k];
         end
      end
   end

   assign trig_valid = v_ff[6];
   always_comb begin
      trig.s1   = sin_ff[0];
      trig.c1   = cos_ff[0];
      trig.s2   = sin_ff[1];
      trig.c2   = cos_ff[1];
      trig.s23  = sin_ff[2];
      trig.c23  = cos_ff[2];
      trig.s234 = sin_ff[3];
      trig.c234 = cos_ff[3];
   end

endmodule

FILE: design/afk_solve.sv
// Back end: rotation products, reach and height sums, position scaling and output register.
module afk_solve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                trig_valid,
   input  afk_pkg::trig_type                   trig,
   input  afk_pkg::link_type                   links,
   output logic                                adv,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r11,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r12,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r13,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r21,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r22,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r23,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r31,
   output logic signed [afk_pkg::TRIG_W-1:0]   rsp_r32,
   output logic signed [afk_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [afk_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [afk_pkg::POS_W-1:0]    rsp_pos_z
);
   import afk_pkg::*;

   localparam int PRD_W   = 2 * TRIG_W;
   localparam int LP_W    = LEN_W + 1 + TRIG_W;
   localparam int REACH_W = 35;
   localparam int SCL_W   = REACH_W + TRIG_W;

   logic [2:0] v_ff;

   // product stage
   trig_type                 tp_ff;
   logic signed [PRD_W-1:0]  cc_ff, cs_ff, sc_ff, ss_ff;
   logic signed [LP_W-1:0]   rc2_ff, rc23_ff, rc234_ff;
   logic signed [LP_W-1:0]   hs2_ff, hs23_ff, hs234_ff;

   // sum stage
   logic signed [TRIG_W-1:0] r11_ff, r12_ff, r13_ff, r21_ff;
   logic signed [TRIG_W-1:0] r22_ff, r23_ff, r31_ff, r32_ff;
   logic signed [TRIG_W-1:0] c1_ff, s1_ff;
   logic signed [REACH_W-1:0] reach_ff;
   logic signed [POS_W-1:0]  pz_ff;

   // scale stage
   logic signed [TRIG_W-1:0] r11b_ff, r12b_ff, r13b_ff, r21b_ff;
   logic signed [TRIG_W-1:0] r22b_ff, r23b_ff, r31b_ff, r32b_ff;
   logic signed [SCL_W-1:0]  px_p_ff, py_p_ff;
   logic signed [POS_W-1:0]  pzb_ff;

   logic signed [TRIG_W:0]    rnd_cc, rnd_cs, rnd_sc, rnd_ss;
   logic signed [TRIG_W:0]    neg_cs, neg_ss;
   logic signed [TRIG_W:0]    neg_c1;
   logic signed [REACH_W-1:0] reach_in, height_in, hr;
   logic signed [REACH_W-1:0] hsh;
   logic signed [POS_W-1:0]   pz_in;
   logic signed [SCL_W-1:0]   vx, vy;
   logic signed [SCL_W-31:0]  shx, shy;
   logic signed [POS_W-1:0]   px_in, py_in;

   assign adv = !(rsp_valid && rsp_stall);

   always_comb begin
      rnd_cc = round_q15(cc_ff);
      rnd_cs = round_q15(cs_ff);
      rnd_sc = round_q15(sc_ff);
      rnd_ss = round_q15(ss_ff);
      neg_cs = -rnd_cs;
      neg_ss = -rnd_ss;
      neg_c1 = -(17'(tp_ff.c1));
      reach_in = $signed({(REACH_W-LEN_W-15)'(0), links.a0, 15'd0})
               + REACH_W'(rc2_ff) + REACH_W'(rc23_ff) + REACH_W'(rc234_ff);
      height_in = REACH_W'(hs2_ff) + REACH_W'(hs23_ff) + REACH_W'(hs234_ff);
      hr  = height_in + REACH_W'(16384);
      hsh = hr >>> 15;
      if (hsh > REACH_W'(524287)) begin
         pz_in = POS_W'(524287);
      end else if (hsh < -REACH_W'(524288)) begin
         pz_in = -POS_W'(524288);
      end else begin
         pz_in = hsh[POS_W-1:0];
      end
      vx  = px_p_ff + SCL_W'(1 << 29);
      vy  = py_p_ff + SCL_W'(1 << 29);
      shx = (SCL_W-30)'(vx >>> 30);
      shy = (SCL_W-30)'(vy >>> 30);
      if (shx > (SCL_W-30)'(524287)) begin
         px_in = POS_W'(524287);
      end else if (shx < -(SCL_W-30)'(524288)) begin
         px_in = -POS_W'(524288);
      end else begin
         px_in = shx[POS_W-1:0];
      end
      if (shy > (SCL_W-30)'(524287)) begin
         py_in = POS_W'(524287);
      end else if (shy < -(SCL_W-30)'(524288)) begin
         py_in = -POS_W'(524288);
      end else begin
         py_in = shy[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         v_ff      <= {v_ff[1:0], trig_valid};
         rsp_valid <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tp_ff    <= trig;
         cc_ff    <= trig.c1 * trig.c234;
         cs_ff    <= trig.c1 * trig.s234;
         sc_ff    <= trig.s1 * trig.c234;
         ss_ff    <= trig.s1 * trig.s234;
         rc2_ff   <= $signed({1'b0, links.a1}) * trig.c2;
         rc23_ff  <= $signed({1'b0, links.a2}) * trig.c23;
         rc234_ff <= $signed({1'b0, links.a3}) * trig.c234;
         hs2_ff   <= $signed({1'b0, links.a1}) * trig.s2;
         hs23_ff  <= $signed({1'b0, links.a2}) * trig.s23;
         hs234_ff <= $signed({1'b0, links.a3}) * trig.s234;

         r11_ff   <= rnd_cc[TRIG_W-1:0];
         r12_ff   <= neg_cs[TRIG_W-1:0];
         r13_ff   <= tp_ff.s1;
         r21_ff   <= rnd_sc[TRIG_W-1:0];
         r22_ff   <= neg_ss[TRIG_W-1:0];
         r23_ff   <= neg_c1[TRIG_W-1:0];
         r31_ff   <= tp_ff.s234;
         r32_ff   <= tp_ff.c234;
         c1_ff    <= tp_ff.c1;
         s1_ff    <= tp_ff.s1;
         reach_ff <= reach_in;
         pz_ff    <= pz_in;

         r11b_ff  <= r11_ff;
         r12b_ff  <= r12_ff;
         r13b_ff  <= r13_ff;
         r21b_ff  <= r21_ff;
         r22b_ff  <= r22_ff;
         r23b_ff  <= r23_ff;
         r31b_ff  <= r31_ff;
         r32b_ff  <= r32_ff;
         px_p_ff  <= reach_ff * c1_ff;
         py_p_ff  <= reach_ff * s1_ff;
         pzb_ff   <= pz_ff;

         rsp_r11   <= r11b_ff;
         rsp_r12   <= r12b_ff;
         rsp_r13   <= r13b_ff;
         rsp_r21   <= r21b_ff;
         rsp_r22   <= r22b_ff;
         rsp_r23   <= r23b_ff;
         rsp_r31   <= r31b_ff;
         rsp_r32   <= r32b_ff;
         rsp_pos_x <= px_in;
         rsp_pos_y <= py_in;
         rsp_pos_z <= pzb_ff;
      end
   end

endmodule

FILE: design/arm_forward_kinematics_4dof.sv
// Top level of the four-joint arm forward kinematics block.
//
// Input channel req_: one word holds four 16-bit binary joint angles
// (65536 is one full turn). Result channel rsp_: one word per input word
// with the eight rotation entries in Q1.15 and the tool position in
// signed Q8.12 metres. Both channels use valid/stall; a word moves at a
// clock edge with valid high and stall low.
// Link lengths a0..a3 (Q4.12) sit in four registers on the csr_ APB port
// at byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// A new word can be taken every cycle while req_stall is low. From acceptance
// to rsp_valid a word passes the front queue, the eight-lane sine pipeline
// (z load, Horner steps, rounding and quadrant fold, one multiplier per lane
// in each stage but the fold), then the product, sum, scale and output stages.
// When rsp_stall is held with rsp_valid high the whole back pipeline freezes;
// the four-word queue keeps taking words until full, then req_stall rises.
// Synchronous reset empties the pipeline and queue and loads the link
// registers with 0, 1597, 1475 and 573.
module arm_forward_kinematics_4dof (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [afk_pkg::ANGLE_W-1:0]            req_joint_one,
   input  logic [afk_pkg::ANGLE_W-1:0]            req_joint_two,
   input  logic [afk_pkg::ANGLE_W-1:0]            req_joint_three,
   input  logic [afk_pkg::ANGLE_W-1:0]            req_joint_four,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r11,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r12,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r13,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r21,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r22,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r23,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r31,
   output logic signed [afk_pkg::TRIG_W-1:0]      rsp_r32,
   output logic signed [afk_pkg::POS_W-1:0]       rsp_pos_x,
   output logic signed [afk_pkg::POS_W-1:0]       rsp_pos_y,
   output logic signed [afk_pkg::POS_W-1:0]       rsp_pos_z,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [afk_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [afk_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [afk_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import afk_pkg::*;

   link_type   links_ff;
   logic [1:0] reg_sel;
   logic       wr_en;

   logic       queue_full;
   logic       push;
   word_type   push_word;
   logic       pop;
   logic       head_valid;
   word_type   head_word;
   logic       adv;
   logic       trig_valid;
   trig_type   trig;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         links_ff.a0 <= '0;
         links_ff.a1 <= UPPER_RESET;
         links_ff.a2 <= FORE_RESET;
         links_ff.a3 <= WRIST_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_BASE_OFFSET: links_ff.a0 <= csr_pwdata[LEN_W-1:0];
            REG_UPPER_LINK:  links_ff.a1 <= csr_pwdata[LEN_W-1:0];
            REG_FORE_LINK:   links_ff.a2 <= csr_pwdata[LEN_W-1:0];
            REG_WRIST_LINK:  links_ff.a3 <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BASE_OFFSET: csr_prdata = CSR_DATA_W'(links_ff.a0);
         REG_UPPER_LINK:  csr_prdata = CSR_DATA_W'(links_ff.a1);
         REG_FORE_LINK:   csr_prdata = CSR_DATA_W'(links_ff.a2);
         REG_WRIST_LINK:  csr_prdata = CSR_DATA_W'(links_ff.a3);
         default:         csr_prdata = '0;
      endcase
   end

   afk_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_joint_one   (req_joint_one),
      .req_joint_two   (req_joint_two),
      .req_joint_three (req_joint_three),
      .req_joint_four  (req_joint_four),
      .queue_full      (queue_full),
      .push            (push),
      .push_word       (push_word)
   );

   afk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   afk_sincos u_sincos (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop        (pop),
      .trig_valid (trig_valid),
      .trig       (trig)
   );

   afk_solve u_solve (
      .clock      (clock),
      .reset      (reset),
      .trig_valid (trig_valid),
      .trig       (trig),
      .links      (links_ff),
      .adv        (adv),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_r11    (rsp_r11),
      .rsp_r12    (rsp_r12),
      .rsp_r13    (rsp_r13),
      .rsp_r21    (rsp_r21),
      .rsp_r22    (rsp_r22),
      .rsp_r23    (rsp_r23),
      .rsp_r31    (rsp_r31),
      .rsp_r32    (rsp_r32),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_pos_z  (rsp_pos_z)
   );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the four-joint arm forward kinematics block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import afk_pkg::*;

   typedef struct packed {
      logic [15:0] j1, j2, j3, j4;
   } joints_type;

   typedef struct packed {
      logic [15:0] r11, r12, r13, r21, r22, r23, r31, r32;
      logic [19:0] px, py, pz;
   } pose_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_joint_one = 0, req_joint_two = 0;
   logic [15:0] req_joint_three = 0, req_joint_four = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_r11, rsp_r12, rsp_r13, rsp_r21;
   logic signed [15:0] rsp_r22, rsp_r23, rsp_r31, rsp_r32;
   logic signed [19:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   arm_forward_kinematics_4dof i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   joints_type pending_joints[$];
   pose_type expected_poses[$];
   longint link_len[4] = '{0, 1597, 1475, 573};
   int errors = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit long_hold_req = 0;
   bit pause_sender = 0;
   bit stim_done = 0;

   function automatic longint half_up(longint p, int k);
      longint v;
      v = p + (longint'(1) << (k - 1));
      return v >>> k;
   endfunction

   function automatic longint quarter_sine(longint r);
      longint unsigned z, z2, t, s, q;
      longint unsigned coef[5];
      coef = '{1686629713, 693598668, 85569305, 5026995, 172272};
      z = r << 16;
      z2 = (z * z) >> 30;
      t = coef[4];
      for (int i = 3; i >= 0; i--) t = coef[i] - ((z2 * t) >> 30);
      s = (z * t) >> 30;
      q = (s + (1 << 14)) >> 15;
      if (q > 32767) q = 32767;
      return longint'(q);
   endfunction

   function automatic void sine_cosine(logic [15:0] a, output longint s, output longint c);
      longint sr, cr;
      sr = quarter_sine(a[13:0]);
      cr = quarter_sine(16384 - a[13:0]);
      case (a[15:14])
         QUAD_0: begin s = sr; c = cr; end
         QUAD_1: begin s = cr; c = -sr; end
         QUAD_2: begin s = -sr; c = -cr; end
         default: begin s = -cr; c = sr; end
      endcase
   endfunction

   function automatic longint clamp_pos(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic pose_type arm_pose(joints_type j);
      pose_type p;
      logic [15:0] a23, a234;
      longint s1, c1, s2, c2, s23, c23, s234, c234, reach, height;
      a23 = j.j2 + j.j3;
      a234 = a23 + j.j4;
      sine_cosine(j.j1, s1, c1);
      sine_cosine(j.j2, s2, c2);
      sine_cosine(a23, s23, c23);
      sine_cosine(a234, s234, c234);
      p.r11 = 16'(half_up(c1 * c234, 15));
      p.r12 = 16'(-half_up(c1 * s234, 15));
      p.r13 = 16'(s1);
      p.r21 = 16'(half_up(s1 * c234, 15));
      p.r22 = 16'(-half_up(s1 * s234, 15));
      p.r23 = 16'(-c1);
      p.r31 = 16'(s234);
      p.r32 = 16'(c234);
      reach = (link_len[0] << 15) + link_len[1] * c2 + link_len[2] * c23
            + link_len[3] * c234;
      height = link_len[1] * s2 + link_len[2] * s23 + link_len[3] * s234;
      p.px = 20'(clamp_pos(half_up(reach * c1, 30)));
      p.py = 20'(clamp_pos(half_up(reach * s1, 30)));
      p.pz = 20'(clamp_pos(half_up(height, 15)));
      return p;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_poses.push_back(arm_pose(
               {req_joint_one, req_joint_two, req_joint_three, req_joint_four}));
            idle_cycles = 0;
            gap_left = pick_gap();
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (!pause_sender && pending_joints.size() > 0) begin
               joints_type j;
               j = pending_joints.pop_front();
               req_valid <= 1;
               req_joint_one <= j.j1;
               req_joint_two <= j.j2;
               req_joint_three <= j.j3;
               req_joint_four <= j.j4;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (expected_poses.size() == 0) begin
               $error("result word with none expected");
               errors++;
            end else begin
               pose_type e;
               e = expected_poses.pop_front();
               if (rsp_r11 !== e.r11) begin
                  $error("r11 exp %0d got %0d", $signed(e.r11), rsp_r11); errors++;
               end
               if (rsp_r12 !== e.r12) begin
                  $error("r12 exp %0d got %0d", $signed(e.r12), rsp_r12); errors++;
               end
               if (rsp_r13 !== e.r13) begin
                  $error("r13 exp %0d got %0d", $signed(e.r13), rsp_r13); errors++;
               end
               if (rsp_r21 !== e.r21) begin
                  $error("r21 exp %0d got %0d", $signed(e.r21), rsp_r21); errors++;
               end
               if (rsp_r22 !== e.r22) begin
                  $error("r22 exp %0d got %0d", $signed(e.r22), rsp_r22); errors++;
               end
               if (rsp_r23 !== e.r23) begin
                  $error("r23 exp %0d got %0d", $signed(e.r23), rsp_r23); errors++;
               end
               if (rsp_r31 !== e.r31) begin
                  $error("r31 exp %0d got %0d", $signed(e.r31), rsp_r31); errors++;
               end
               if (rsp_r32 !== e.r32) begin
                  $error("r32 exp %0d got %0d", $signed(e.r32), rsp_r32); errors++;
               end
               if (rsp_pos_x !== e.px) begin
                  $error("pos_x exp %0d got %0d", $signed(e.px), rsp_pos_x); errors++;
               end
               if (rsp_pos_y !== e.py) begin
                  $error("pos_y exp %0d got %0d", $signed(e.py), rsp_pos_y); errors++;
               end
               if (rsp_pos_z !== e.pz) begin
                  $error("pos_z exp %0d got %0d", $signed(e.pz), rsp_pos_z); errors++;
               end
            end
         end
         if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if ($urandom_range(0, 2) == 0) begin
            hold_left = pick_gap();
            rsp_stall <= (hold_left > 0);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (idle_cycles > 5000) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic csr_write(int idx, logic [15:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= CSR_ADDR_W'(idx * 4);
      csr_pwdata <= {16'($urandom_range(0, 65535)), val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      link_len[idx] = val;
   endtask

   task automatic drain();
      while (pending_joints.size() > 0 || req_valid || expected_poses.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_joints(logic [15:0] a, b, c, d);
      pending_joints.push_back({a, b, c, d});
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 3)) << 14;
         1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      logic [15:0] edge_angles[8];
      edge_angles = '{16'h0000, 16'hffff, 16'h4000, 16'h8000,
                      16'hc000, 16'h3fff, 16'h2000, 16'h0001};
      repeat (7) @(posedge clock);
      reset <= 0;
      // directed: quadrant edges, full-scale values, wrapping sums
      for (int i = 0; i < 8; i++)
         push_joints(edge_angles[i], edge_angles[(i + 1) % 8], edge_angles[(i + 3) % 8],
                     edge_angles[(i + 5) % 8]);
      push_joints(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      push_joints(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_joints(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
      push_joints(16'h0000, 16'h8000, 16'h8000, 16'h0000);
      drain();
      // extremes of the links, then moderate and random link values, with saturating position
      for (int phase = 0; phase < 5; phase++) begin
         for (int r = 0; r < 4; r++) begin
            case (phase)
               0: csr_write(r, 16'hffff);
               1: csr_write(r, 16'h0000);
               2: csr_write(r, (r == 0) ? 16'h0000 : 16'h4000);
               default: csr_write(r, 16'($urandom_range(0, 65535)));
            endcase
         end
         for (int n = 0; n < 250; n++) begin
            push_joints(rand_angle(), rand_angle(), rand_angle(), rand_angle());
            if (n == 100 && phase == 1) long_hold_req = 1;
         end
         if (phase == 2) begin
            while (pending_joints.size() > 125) @(posedge clock);
            pause_sender = 1;
            while (expected_poses.size() > 0 || req_valid) @(posedge clock);
            pause_sender = 0;
         end
         drain();
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
